@@ design/bspl_pkg.sv @@
// Shared types and constants for the B-spline curve point evaluator.
`timescale 1ns / 1ps
package bspl_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned SpanW   = 6;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CfgDW   = 6;
  localparam int unsigned NumW    = 49;  // (t - u_a) scaled by 2^16
  localparam int unsigned DenW    = 33;  // knot difference or point difference
  localparam int unsigned MagW    = 48;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned AlphaW  = 31;
  localparam int unsigned AlphaMagW = 30;
  localparam int unsigned CntW    = 6;
  localparam logic [MagW-1:0] AlphaLimit = MagW'(536870912);

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_POINT = 2'd0,
    CMD_LOAD_KNOT  = 2'd1,
    CMD_EVAL       = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_POINT_COUNT  = 1'b0,
    CFG_CURVE_DEGREE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     go;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } pnt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LO_RD,
    S_LO_CMP,
    S_HI_RD,
    S_HI_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LD_RD,
    S_LD_WR,
    S_UA_RD,
    S_UB_RD,
    S_UB_CAP,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DONE
  } state_t;

endpackage

@@ design/bspl_serial_unit.sv @@
// Shared bit-serial signed divider and multiplier used for alpha and the blends.
`timescale 1ns / 1ps
module bspl_serial_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bspl_pkg::unit_ctl_t                 ctl,
  input  logic signed [bspl_pkg::NumW-1:0]    op_a,
  input  logic signed [bspl_pkg::DenW-1:0]    op_b,
  output logic                                done,
  output logic signed [bspl_pkg::ProdW-1:0]   result
);
  import bspl_pkg::*;

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  unit_op_t        op_r, op_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [MagW-1:0] shreg_r, shreg_nxt;
  logic [DenW-1:0] rem_r, rem_nxt;
  logic [ProdW-1:0] acc_r, acc_nxt;
  logic [DenW-1:0] dmag_r, dmag_nxt;
  logic            neg_r, neg_nxt;

  logic [MagW-1:0] amag;
  logic [DenW-1:0] bmag;
  logic [DenW:0]   trial;
  logic [MagW-1:0] qsat;

  always_comb begin
    amag = op_a[NumW-1] ? MagW'(-op_a) : MagW'(op_a);
    bmag = op_b[DenW-1] ? DenW'(-op_b) : DenW'(op_b);
    trial = {rem_r, shreg_r[MagW-1]};
    run_nxt = run_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    shreg_nxt = shreg_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    dmag_nxt = dmag_r;
    neg_nxt = neg_r;
    if (ctl.go) begin
      run_nxt = 1'b1;
      op_nxt = ctl.op;
      neg_nxt = op_a[NumW-1] ^ op_b[DenW-1];
      dmag_nxt = bmag;
      rem_nxt = '0;
      acc_nxt = '0;
      if (ctl.op == OP_DIV) begin
        shreg_nxt = amag;
        cnt_nxt = CntW'(MagW);
      end else begin
        shreg_nxt = {amag[AlphaMagW-1:0], {(MagW-AlphaMagW){1'b0}}};
        cnt_nxt = CntW'(AlphaMagW);
      end
    end else if (run_r) begin
      if (op_r == OP_DIV) begin
        if (trial >= {1'b0, dmag_r}) begin
          rem_nxt = DenW'(trial - {1'b0, dmag_r});
          shreg_nxt = {shreg_r[MagW-2:0], 1'b1};
        end else begin
          rem_nxt = DenW'(trial);
          shreg_nxt = {shreg_r[MagW-2:0], 1'b0};
        end
      end else begin
        acc_nxt = {acc_r[ProdW-2:0], 1'b0} +
                  (shreg_r[MagW-1] ? ProdW'(dmag_r) : '0);
        shreg_nxt = {shreg_r[MagW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    shreg_r <= shreg_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    dmag_r <= dmag_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    qsat = (shreg_r > AlphaLimit) ? AlphaLimit : shreg_r;
    if (op_r == OP_DIV) begin
      result = neg_r ? -ProdW'(qsat) : ProdW'(qsat);
    end else begin
      result = neg_r ? -acc_r : acc_r;
    end
  end

  assign done = done_r;

endmodule

@@ design/bspline_curve_point_eval.sv @@
// Top level of the B-spline curve point evaluator (de Boor's algorithm, Q16.16).
`timescale 1ns / 1ps
// Load commands leave busy low. An evaluation holds busy through the end checks, a binary
// search over the knots when the end checks do not settle the span, the point fetch,
// degree*(degree+1)/2 blends of an alpha divide (skipped on a zero knot gap) and three
// multiplies each, and a final step; the bit-serial shared unit does the divides and
// multiplies. The result strobe comes in the cycle in which busy is low again. Reset is
// synchronous, clears control and sets the configuration to four points of degree three;
// stores are undefined until loaded. Results cannot stall.
module bspline_curve_point_eval #(
  parameter int MAX_POINTS = 32,
  parameter int MAX_DEGREE = 7,
  parameter int KNOT_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [bspl_pkg::CmdW-1:0]              in_command,
  input  logic [bspl_pkg::SlotW-1:0]             in_slot_index,
  input  logic signed [bspl_pkg::CoordW-1:0]     in_coord_x,
  input  logic signed [bspl_pkg::CoordW-1:0]     in_coord_y,
  input  logic signed [bspl_pkg::CoordW-1:0]     in_coord_z,
  input  logic signed [bspl_pkg::CoordW-1:0]     in_scalar_value,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [bspl_pkg::CfgDW-1:0]             cfg_wdata,
  output logic                                   out_valid,
  output logic signed [bspl_pkg::CoordW-1:0]     out_point_x,
  output logic signed [bspl_pkg::CoordW-1:0]     out_point_y,
  output logic signed [bspl_pkg::CoordW-1:0]     out_point_z,
  output logic [bspl_pkg::SpanW-1:0]             out_span_found
);
  import bspl_pkg::*;

  // Index width covers every knot index the algorithm forms and the knot depth,
  // with one spare bit so that out-of-range indices stay visible.
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int KAW = $clog2(KNOT_DEPTH);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int IW0 = $clog2(MAX_POINTS + MAX_DEGREE + 1);
  localparam int IW  = ((IW0 > KAW) ? IW0 : KAW) + 1;

  // Configuration registers.
  logic [CfgDW-1:0] point_count_r;
  logic [2:0]       curve_degree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CfgDW'(4);
      curve_degree_r <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POINT_COUNT:  point_count_r <= cfg_wdata;
        CFG_CURVE_DEGREE: curve_degree_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers.
  state_t state_r, state_nxt;
  logic signed [CoordW-1:0] t_r, t_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic [DW-1:0] p_r, p_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] low_r, low_nxt;
  logic [IW-1:0] high_r, high_nxt;
  logic [DW-1:0] i_r, i_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [1:0]    c_r, c_nxt;
  logic signed [CoordW-1:0] ua_r, ua_nxt;
  logic signed [AlphaW-1:0] alpha_r, alpha_nxt;
  pnt_t lo_r, lo_nxt;
  pnt_t hi_r, hi_nxt;
  logic out_valid_r, out_valid_nxt;
  pnt_t res_r, res_nxt;
  logic [SpanW-1:0] span_r, span_nxt;

  // Working points of the de Boor triangle.
  pnt_t d_r [MAX_DEGREE+1];
  logic          d_we;
  logic [DW-1:0] d_waddr;
  pnt_t          d_wdata;
  logic [DW-1:0] d_raddr;
  pnt_t          d_rd;

  // Stores with registered read.
  logic signed [CoordW-1:0] ctrl_x_mem [MAX_POINTS];
  logic signed [CoordW-1:0] ctrl_y_mem [MAX_POINTS];
  logic signed [CoordW-1:0] ctrl_z_mem [MAX_POINTS];
  logic signed [CoordW-1:0] knot_mem [KNOT_DEPTH];
  logic [PAW-1:0] ctrl_raddr;
  pnt_t ctrl_rd_r;
  logic [IW-1:0] kidx;
  logic signed [CoordW-1:0] krd_r;
  logic koob_r;
  logic signed [CoordW-1:0] kv;

  logic accept;
  logic pt_we, kn_we;
  logic [IW-1:0] cnt_c;
  logic [DW-1:0] p_c;
  logic [IW-1:0] mid;
  logic [IW-1:0] cidx;
  logic signed [DenW-1:0] den;
  logic signed [DenW-1:0] tdiff;

  unit_ctl_t u_ctl;
  logic signed [NumW-1:0]  u_a;
  logic signed [DenW-1:0]  u_b;
  logic                    u_done;
  logic signed [ProdW-1:0] u_result;

  logic signed [CoordW-1:0] lo_c, hi_c;
  logic signed [ProdW-CoordW/2-1:0] shq;
  logic signed [ProdW-CoordW/2:0]   bsum;
  logic signed [CoordW-1:0] bval;

  assign accept = start && !busy;
  assign pt_we = accept && (cmd_t'(in_command) == CMD_LOAD_POINT) &&
                 (int'(in_slot_index) < MAX_POINTS);
  assign kn_we = accept && (cmd_t'(in_command) == CMD_LOAD_KNOT) &&
                 (int'(in_slot_index) < KNOT_DEPTH);

  always_ff @(posedge clk) begin
    if (pt_we) begin
      ctrl_x_mem[PAW'(in_slot_index)] <= in_coord_x;
      ctrl_y_mem[PAW'(in_slot_index)] <= in_coord_y;
      ctrl_z_mem[PAW'(in_slot_index)] <= in_coord_z;
    end
    ctrl_rd_r.x <= ctrl_x_mem[ctrl_raddr];
    ctrl_rd_r.y <= ctrl_y_mem[ctrl_raddr];
    ctrl_rd_r.z <= ctrl_z_mem[ctrl_raddr];
  end

  always_ff @(posedge clk) begin
    if (kn_we) begin
      knot_mem[KAW'(in_slot_index)] <= in_scalar_value;
    end
    krd_r <= knot_mem[kidx[KAW-1:0]];
    koob_r <= (int'(kidx) >= KNOT_DEPTH);
  end

  // Knots past the store read as zero.
  assign kv = koob_r ? '0 : krd_r;

  always_ff @(posedge clk) begin
    if (d_we) begin
      d_r[d_waddr] <= d_wdata;
    end
  end
  assign d_rd = d_r[d_raddr];

  // Clamped point count and degree, taken when an evaluation starts.
  always_comb begin
    if (point_count_r == '0) begin
      cnt_c = IW'(1);
    end else if (int'(point_count_r) > MAX_POINTS) begin
      cnt_c = IW'(MAX_POINTS);
    end else begin
      cnt_c = IW'(point_count_r);
    end
    if (int'(curve_degree_r) > MAX_DEGREE) begin
      p_c = DW'(MAX_DEGREE);
    end else begin
      p_c = DW'(curve_degree_r);
    end
    if (IW'(p_c) > cnt_c - IW'(1)) begin
      p_c = DW'(cnt_c - IW'(1));
    end
  end

  assign mid  = IW'(({1'b0, low_r} + {1'b0, high_r}) >> 1);
  assign cidx = IW'(k_r + IW'(i_r) - IW'(p_r));
  assign den  = {kv[CoordW-1], kv} - {ua_r[CoordW-1], ua_r};
  assign tdiff = {t_r[CoordW-1], t_r} - {ua_r[CoordW-1], ua_r};
  assign ctrl_raddr = PAW'(cidx);

  always_comb begin
    case (c_r)
      2'd0:    begin lo_c = lo_r.x; hi_c = hi_r.x; end
      2'd1:    begin lo_c = lo_r.y; hi_c = hi_r.y; end
      default: begin lo_c = lo_r.z; hi_c = hi_r.z; end
    endcase
  end

  // Blend: lo + floor(alpha * (hi - lo) / 2^16), saturated to 32 bits.
  always_comb begin
    shq = u_result[ProdW-1:CoordW/2];
    bsum = (ProdW-CoordW/2+1)'(lo_c) + (ProdW-CoordW/2+1)'(shq);
    if (bsum > (ProdW-CoordW/2+1)'(32'sh7fffffff)) begin
      bval = 32'sh7fffffff;
    end else if (bsum < -(ProdW-CoordW/2+1)'(33'sh080000000)) begin
      bval = 32'sh80000000;
    end else begin
      bval = CoordW'(bsum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt = t_r;
    n_nxt = n_r;
    p_nxt = p_r;
    k_nxt = k_r;
    low_nxt = low_r;
    high_nxt = high_r;
    i_nxt = i_r;
    r_nxt = r_r;
    c_nxt = c_r;
    ua_nxt = ua_r;
    alpha_nxt = alpha_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    res_nxt = res_r;
    span_nxt = span_r;
    out_valid_nxt = 1'b0;
    kidx = IW'(p_r);
    d_raddr = i_r;
    d_we = 1'b0;
    d_waddr = i_r;
    d_wdata = d_rd;
    u_ctl.go = 1'b0;
    u_ctl.op = OP_DIV;
    u_a = {tdiff, 16'b0};
    u_b = den;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (cmd_t'(in_command) == CMD_EVAL)) begin
          t_nxt = in_scalar_value;
          n_nxt = cnt_c - IW'(1);
          p_nxt = p_c;
          state_nxt = S_LO_RD;
        end
      end
      S_LO_RD: begin
        kidx = IW'(p_r);
        state_nxt = S_LO_CMP;
      end
      S_LO_CMP: begin
        if (t_r < kv) begin
          k_nxt = IW'(p_r);
          i_nxt = '0;
          state_nxt = S_LD_RD;
        end else begin
          state_nxt = S_HI_RD;
        end
      end
      S_HI_RD: begin
        kidx = n_r + IW'(1);
        state_nxt = S_HI_CMP;
      end
      S_HI_CMP: begin
        i_nxt = '0;
        if (t_r >= kv) begin
          k_nxt = n_r;
          state_nxt = S_LD_RD;
        end else if (n_r + IW'(1) - IW'(p_r) > IW'(1)) begin
          low_nxt = IW'(p_r);
          high_nxt = n_r + IW'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          k_nxt = IW'(p_r);
          state_nxt = S_LD_RD;
        end
      end
      S_SRCH_RD: begin
        kidx = mid;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (t_r < kv) begin
          high_nxt = mid;
        end else begin
          low_nxt = mid;
        end
        if (high_nxt - low_nxt > IW'(1)) begin
          state_nxt = S_SRCH_RD;
        end else begin
          k_nxt = low_nxt;
          i_nxt = '0;
          state_nxt = S_LD_RD;
        end
      end
      S_LD_RD: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        d_we = 1'b1;
        d_wdata = ctrl_rd_r;
        if (i_r == p_r) begin
          if (p_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            r_nxt = DW'(1);
            i_nxt = p_r;
            state_nxt = S_UA_RD;
          end
        end else begin
          i_nxt = i_r + DW'(1);
          state_nxt = S_LD_RD;
        end
      end
      S_UA_RD: begin
        kidx = cidx;
        d_raddr = i_r;
        hi_nxt = d_rd;
        state_nxt = S_UB_RD;
      end
      S_UB_RD: begin
        ua_nxt = kv;
        kidx = IW'(IW'(i_r) + k_r - IW'(r_r) + IW'(1));
        d_raddr = i_r - DW'(1);
        lo_nxt = d_rd;
        state_nxt = S_UB_CAP;
      end
      S_UB_CAP: begin
        c_nxt = 2'd0;
        if (den == '0) begin
          alpha_nxt = '0;
          state_nxt = S_MUL_GO;
        end else begin
          u_ctl.go = 1'b1;
          u_ctl.op = OP_DIV;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (u_done) begin
          alpha_nxt = AlphaW'(u_result);
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        u_ctl.go = 1'b1;
        u_ctl.op = OP_MUL;
        u_a = NumW'(alpha_r);
        u_b = DenW'(hi_c) - DenW'(lo_c);
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        d_raddr = i_r;
        if (u_done) begin
          d_we = 1'b1;
          d_wdata = d_rd;
          case (c_r)
            2'd0:    d_wdata.x = bval;
            2'd1:    d_wdata.y = bval;
            default: d_wdata.z = bval;
          endcase
          if (c_r != 2'd2) begin
            c_nxt = c_r + 2'd1;
            state_nxt = S_MUL_GO;
          end else if (i_r == r_r) begin
            if (r_r == p_r) begin
              state_nxt = S_DONE;
            end else begin
              r_nxt = r_r + DW'(1);
              i_nxt = p_r;
              state_nxt = S_UA_RD;
            end
          end else begin
            i_nxt = i_r - DW'(1);
            state_nxt = S_UA_RD;
          end
        end
      end
      S_DONE: begin
        d_raddr = p_r;
        res_nxt = d_rd;
        span_nxt = SpanW'(k_r);
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r <= t_nxt;
    n_r <= n_nxt;
    p_r <= p_nxt;
    k_r <= k_nxt;
    low_r <= low_nxt;
    high_r <= high_nxt;
    i_r <= i_nxt;
    r_r <= r_nxt;
    c_r <= c_nxt;
    ua_r <= ua_nxt;
    alpha_r <= alpha_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    res_r <= res_nxt;
    span_r <= span_nxt;
  end

  bspl_serial_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (u_ctl),
    .op_a   (u_a),
    .op_b   (u_b),
    .done   (u_done),
    .result (u_result)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_point_x = res_r.x;
  assign out_point_y = res_r.y;
  assign out_point_z = res_r.z;
  assign out_span_found = span_r;

  // A result transfer only follows the final step of an evaluation.
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished evaluation");

  // The shared unit only finishes while the sequencer waits for it.
  a_unit_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == S_DIV_WAIT || state_r == S_MUL_WAIT))
    else $error("unit finished outside a wait state");

  // An accepted evaluate command makes the block busy.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_t'(in_command) == CMD_EVAL) |=> busy)
    else $error("evaluate accepted but block not busy");

  // The chosen span lies between the degree and the last point index.
  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (k_r >= IW'(p_r) && k_r <= n_r))
    else $error("span index outside its valid range");

endmodule
